// ===== rtl/core/response_frame_deframer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Response frame deframer assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define RESPONSE_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rfd same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rfd next-cycle check failed");

`endif

// ===== rtl/core/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Response frame deframer package
// Word types, register indexes, error codes and fixed constants.
// ----------------------------------------------------------------------------
package rfd_pkg;

	// Byte counter, saturating
	localparam int unsigned CNT_W       = 9;
	localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

	// Shortest legal buffer and bytes packed into the callback word
	localparam int unsigned MIN_BUFFER  = 6;
	localparam int unsigned PACK_BYTES  = 4;
	localparam int unsigned CB_CNT_W    = 3;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STOP_MARKER  = 1'd1;
	localparam logic [7:0] START_MARKER_RST = 8'd221;
	localparam logic [7:0] STOP_MARKER_RST  = 8'd119;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_TOO_SHORT = 3'd1,
		ERR_BAD_START = 3'd2,
		ERR_TRUNCATED = 3'd3,
		ERR_CHECKSUM  = 3'd4,
		ERR_BAD_STOP  = 3'd5
	} err_code_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic        frame_done;
		logic        frame_ok;
		logic [2:0]  error_code;
		logic [7:0]  cmd_code;
		logic [7:0]  status_code;
		logic [7:0]  data_length;
		logic [2:0]  callback_length;
		logic [31:0] callback_tag;
	} out_word_t;

endpackage

// ===== rtl/core/rfd_if.sv =====
// ----------------------------------------------------------------------------
// Response frame deframer channels
// Valid/ready channels for received bytes and for result words.
// ----------------------------------------------------------------------------
interface rfd_in_if;
	logic              valid;
	logic              ready;
	rfd_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rfd_out_if;
	logic               valid;
	logic               ready;
	rfd_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/response_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Response frame deframer
// Parses start, command, status, length, payload, 16-bit additive checksum,
// stop marker and callback bytes from a byte stream; one result per byte.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  accepted when
//  rx       in   rx_byte, end_of_buffer                   rx.valid & rx.ready
//  res      out  payload fields, verdict, header, cb id   res.valid & res.ready
//  cfg      in   cfg_index, cfg_wdata                     cfg_we
//
//  One byte per cycle while the result register is free or draining; the
//  result appears in the cycle after its byte is taken. The byte counter and
//  running sum are updated combinationally and registered with each byte.
//  Reset clears all frame state; markers return to 221 (start) and 119 (stop).
//  A stalled result holds in the output register; a new byte is taken while
//  the register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module response_frame_deframer_top #(
	parameter int unsigned MAX_CALLBACK_BYTES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rfd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	rfd_in_if.sink                            rx,
	rfd_out_if.source                         res
);

	localparam int unsigned CB_CAP  = (MAX_CALLBACK_BYTES > 7) ? 7 : MAX_CALLBACK_BYTES;
	localparam int unsigned CB_PACK = (MAX_CALLBACK_BYTES > rfd_pkg::PACK_BYTES) ?
		rfd_pkg::PACK_BYTES : MAX_CALLBACK_BYTES;
	localparam logic [rfd_pkg::CB_CNT_W-1:0] CbCap = rfd_pkg::CB_CNT_W'(CB_CAP);

	logic [7:0] start_marker_q;
	logic [7:0] stop_marker_q;

	logic [rfd_pkg::CNT_W-1:0]    byte_count_q, byte_count_d;
	logic                         start_good_q, start_good_d;
	logic [7:0]                   cmd_q, cmd_d;
	logic [7:0]                   status_q, status_d;
	logic [7:0]                   length_q, length_d;
	logic [15:0]                  sum_q, sum_d;
	logic [15:0]                  recv_sum_q, recv_sum_d;
	logic                         stop_good_q, stop_good_d;
	logic [31:0]                  cb_bytes_q, cb_bytes_d;
	logic [rfd_pkg::CB_CNT_W-1:0] cb_count_q, cb_count_d;

	logic                 out_valid_q;
	rfd_pkg::out_word_t   out_q;
	rfd_pkg::out_word_t   res_d;
	rfd_pkg::err_code_t   err;

	logic [7:0]  b;
	logic        last;
	logic        acc;
	logic [9:0]  pos_w;
	logic [9:0]  pay_end;
	logic [9:0]  n_bytes;
	logic [15:0] expect_sum;

	assign b    = rx.data.rx_byte;
	assign last = rx.data.end_of_buffer;

	// Take a byte whenever the result register is free or draining
	assign rx.ready  = !out_valid_q || res.ready;
	assign acc       = rx.valid && rx.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= rfd_pkg::START_MARKER_RST;
			stop_marker_q  <= rfd_pkg::STOP_MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rfd_pkg::REG_START_MARKER: start_marker_q <= cfg_wdata;
				rfd_pkg::REG_STOP_MARKER:  stop_marker_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next frame state and result word for the byte on the input
	always_comb begin
		pos_w    = {1'b0, byte_count_q};
		pay_end  = {2'b00, length_q} + 10'd4;
		n_bytes  = pos_w + 10'd1;

		start_good_d = start_good_q;
		cmd_d        = cmd_q;
		status_d     = status_q;
		length_d     = length_q;
		sum_d        = sum_q;
		recv_sum_d   = recv_sum_q;
		stop_good_d  = stop_good_q;
		cb_bytes_d   = cb_bytes_q;
		cb_count_d   = cb_count_q;
		res_d        = '0;

		if (pos_w == 10'd0) begin
			start_good_d = (b == start_marker_q);
		end else if (pos_w == 10'd1) begin
			cmd_d = b;
		end else if (pos_w == 10'd2) begin
			status_d = b;
			sum_d    = sum_q + {8'h00, b};
		end else if (pos_w == 10'd3) begin
			length_d = b;
			sum_d    = sum_q + {8'h00, b};
		end else if (pos_w < pay_end) begin
			sum_d = sum_q + {8'h00, b};
			if (start_good_q) begin
				res_d.payload_valid = 1'b1;
				res_d.payload_byte  = b;
				res_d.payload_index = 8'(pos_w - 10'd4);
			end
		end else if (pos_w == pay_end) begin
			recv_sum_d[15:8] = b;
		end else if (pos_w == pay_end + 10'd1) begin
			recv_sum_d[7:0] = b;
		end else if (pos_w == pay_end + 10'd2) begin
			stop_good_d = (b == stop_marker_q);
		end else if (cb_count_q < CbCap) begin
			// Pack callback bytes big-endian, first byte in the top lane
			for (int k = 0; k < rfd_pkg::PACK_BYTES; k++) begin
				if (k < CB_PACK && cb_count_q == rfd_pkg::CB_CNT_W'(k)) begin
					cb_bytes_d[31-8*k -: 8] = cb_bytes_q[31-8*k -: 8] | b;
				end
			end
			cb_count_d = cb_count_q + 1'b1;
		end

		byte_count_d = (byte_count_q != rfd_pkg::CNT_MAX) ? byte_count_q + 1'b1 :
			byte_count_q;

		// Verdict, first failing check wins
		expect_sum = 16'h0000 - sum_d;
		if (n_bytes < 10'(rfd_pkg::MIN_BUFFER)) begin
			err = rfd_pkg::ERR_TOO_SHORT;
		end else if (!start_good_d) begin
			err = rfd_pkg::ERR_BAD_START;
		end else if (n_bytes < {2'b00, length_d} + 10'd7) begin
			err = rfd_pkg::ERR_TRUNCATED;
		end else if (expect_sum != recv_sum_d) begin
			err = rfd_pkg::ERR_CHECKSUM;
		end else if (!stop_good_d) begin
			err = rfd_pkg::ERR_BAD_STOP;
		end else begin
			err = rfd_pkg::ERR_NONE;
		end

		if (last) begin
			res_d.frame_done = 1'b1;
			res_d.error_code = err;
			if (err == rfd_pkg::ERR_NONE) begin
				res_d.frame_ok        = 1'b1;
				res_d.cmd_code        = cmd_d;
				res_d.status_code     = status_d;
				res_d.data_length     = length_d;
				res_d.callback_length = cb_count_d;
				res_d.callback_tag    = cb_bytes_d;
			end
		end
	end

	// Frame state: advance on each byte, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			start_good_q <= 1'b0;
			cmd_q        <= '0;
			status_q     <= '0;
			length_q     <= '0;
			sum_q        <= '0;
			recv_sum_q   <= '0;
			stop_good_q  <= 1'b0;
			cb_bytes_q   <= '0;
			cb_count_q   <= '0;
		end else if (acc) begin
			if (last) begin
				byte_count_q <= '0;
				start_good_q <= 1'b0;
				cmd_q        <= '0;
				status_q     <= '0;
				length_q     <= '0;
				sum_q        <= '0;
				recv_sum_q   <= '0;
				stop_good_q  <= 1'b0;
				cb_bytes_q   <= '0;
				cb_count_q   <= '0;
			end else begin
				byte_count_q <= byte_count_d;
				start_good_q <= start_good_d;
				cmd_q        <= cmd_d;
				status_q     <= status_d;
				length_q     <= length_d;
				sum_q        <= sum_d;
				recv_sum_q   <= recv_sum_d;
				stop_good_q  <= stop_good_d;
				cb_bytes_q   <= cb_bytes_d;
				cb_count_q   <= cb_count_d;
			end
		end
	end

	// Result register valid: set on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word, loaded with each accepted byte
	always_ff @(posedge clk) begin
		if (acc) begin
			out_q <= res_d;
		end
	end

`include "response_frame_deframer_top_assert.svh"

	`RFD_ASSERT_SAME(a_ok_has_no_error, clk, arst_n, out_valid_q && out_q.frame_ok, out_q.frame_done && out_q.error_code == rfd_pkg::ERR_NONE)
	`RFD_ASSERT_NEXT(a_clear_after_last, clk, arst_n, acc && last, byte_count_q == '0 && !start_good_q && cb_count_q == '0)
	`RFD_ASSERT_NEXT(a_count_step, clk, arst_n, acc && !last && byte_count_q != rfd_pkg::CNT_MAX, byte_count_q == $past(byte_count_q) + 1'b1)
	`RFD_ASSERT_SAME(a_cb_count_cap, clk, arst_n, 1'b1, cb_count_q <= CbCap)

endmodule
